@@ rtl/wcpp_pkg.sv @@
package wcpp_pkg;

  // field widths
  localparam int unsigned PosW  = 32;
  localparam int unsigned HdgW  = 16;
  localparam int unsigned IdxW  = 12;
  localparam int unsigned CostW = 40;
  localparam int unsigned WgtW  = 32;

  // distance datapath
  localparam int unsigned AbsW  = 32;   // |p - ego| per axis
  localparam int unsigned SqW   = 64;   // one square
  localparam int unsigned SumW  = 66;   // sum of three squares
  localparam int unsigned RootW = 33;   // root bits, one per step
  localparam int unsigned RemW  = 36;   // partial remainder
  localparam int unsigned AngW  = 17;   // |yaw error|, up to half a turn

  // queue between front and back
  localparam int unsigned QDepth = 4;

  localparam logic [CostW-1:0] CostMax = '1;

  typedef enum logic [1:0] {
    KIND_EGO  = 2'd0,
    KIND_EVAL = 2'd1,
    KIND_SKIP = 2'd2
  } item_kind_e;

  typedef struct packed {
    item_kind_e             kind;
    logic                   last;
    logic [IdxW-1:0]        idx;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic signed [HdgW-1:0] hdg;
  } fb_item_t;

endpackage

@@ rtl/wcpp_front.sv @@
module wcpp_front import wcpp_pkg::*; #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic                   req_type_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  input  logic signed [HdgW-1:0] heading_i,
  input  logic                   last_i,
  output logic                   q_push_o,
  output fb_item_t               q_item_o,
  input  logic                   q_full_i
);

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            at_cap;

  assign full     = q_full_i;
  assign accept   = push && !q_full_i;
  assign q_push_o = accept;
  assign at_cap   = (cnt_q == CntW'(MAX_POINTS));

  // classify the beat and track the point index
  always_comb begin
    q_item_o.last = last_i;
    q_item_o.x    = pos_x_i;
    q_item_o.y    = pos_y_i;
    q_item_o.z    = pos_z_i;
    q_item_o.hdg  = heading_i;
    q_item_o.idx  = IdxW'(cnt_q);
    cnt_d         = cnt_q;
    if (!req_type_i) begin
      q_item_o.kind = KIND_EGO;
      cnt_d         = '0;
    end else if (at_cap) begin
      q_item_o.kind = KIND_SKIP;
      if (last_i) cnt_d = '0;
    end else begin
      q_item_o.kind = KIND_EVAL;
      cnt_d         = last_i ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/wcpp_queue.sv @@
module wcpp_queue import wcpp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fb_item_t item_i,
  output logic     full_o,
  input  logic     pop_i,
  output fb_item_t item_o,
  output logic     valid_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  fb_item_t        mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ rtl/wcpp_back.sv @@
module wcpp_back import wcpp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WgtW-1:0]  cfg_wdata_i,
  input  logic             q_valid_i,
  input  fb_item_t         q_item_i,
  output logic             q_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic             found_o,
  output logic [IdxW-1:0]  best_index_o,
  output logic [CostW-1:0] best_cost_o,
  output logic             overflow_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_ROOT = 5'b01000,
    ST_DONE = 5'b10000
  } back_state_e;

  back_state_e state_q;

  logic [WgtW-1:0]        weight_q;
  logic signed [PosW-1:0] ego_x_q, ego_y_q, ego_z_q;
  logic [HdgW-1:0]        ego_hdg_q;

  logic [IdxW-1:0]  min_idx_q;
  logic [CostW-1:0] min_cost_q;
  logic             ovf_q;

  logic [IdxW-1:0]  cur_idx_q;
  logic             cur_last_q;
  logic [AbsW-1:0]  ax_q, ay_q, az_q;
  logic [AngW-1:0]  ang_q;
  logic [SqW-1:0]   sx_q, sy_q, sz_q;
  logic [WgtW+AngW-1:0] hprod_q;
  logic [WgtW+1:0]  term_q;
  logic [SumW-1:0]  s_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [5:0]       step_q;

  logic             out_valid_q, out_found_q, out_ovf_q;
  logic [IdxW-1:0]  out_idx_q;
  logic [CostW-1:0] out_cost_q;

  logic             take;
  logic [PosW:0]    dx, dy, dz;
  logic [HdgW-1:0]  yaw_err;
  logic [AngW-1:0]  ang;
  logic [RemW-1:0]  rem_t, trial;
  logic [RootW:0]   root_rnd;
  logic [CostW-1:0] cost;
  logic             better;
  logic [WgtW+AngW:0] hround;

  assign empty        = !out_valid_q;
  assign found_o      = out_found_q;
  assign best_index_o = out_idx_q;
  assign best_cost_o  = out_cost_q;
  assign overflow_o   = out_ovf_q;

  // a closing beat only starts once the result slot is free
  assign take    = (state_q == ST_IDLE) && q_valid_i && (!q_item_i.last || !out_valid_q);
  assign q_pop_o = take;

  // per-axis offsets and yaw error
  always_comb begin
    dx      = {q_item_i.x[PosW-1], q_item_i.x} - {ego_x_q[PosW-1], ego_x_q};
    dy      = {q_item_i.y[PosW-1], q_item_i.y} - {ego_y_q[PosW-1], ego_y_q};
    dz      = {q_item_i.z[PosW-1], q_item_i.z} - {ego_z_q[PosW-1], ego_z_q};
    yaw_err = q_item_i.hdg - ego_hdg_q;
    ang     = yaw_err[HdgW-1] ? (AngW'(1 << HdgW) - {1'b0, yaw_err}) : {1'b0, yaw_err};
  end

  // one root digit per step, remainder kept
  assign rem_t = {rem_q[RemW-3:0], s_q[SumW-1 -: 2]};
  assign trial = RemW'({root_q, 2'b01});

  // final cost; the sum stays well below the 40-bit limit
  assign hround   = (WgtW+AngW+1)'(hprod_q) + (WgtW+AngW+1)'(1 << 15);
  assign root_rnd = {1'b0, root_q} + ((rem_q > RemW'(root_q)) ? 1'b1 : 1'b0);
  assign cost     = CostW'(root_rnd) + CostW'(term_q);
  assign better   = (cost < min_cost_q);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
    end else if (cfg_we_i) begin
      weight_q <= cfg_wdata_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cur_idx_q  <= q_item_i.idx;
        cur_last_q <= q_item_i.last;
        ax_q  <= dx[PosW] ? AbsW'(-dx) : AbsW'(dx);
        ay_q  <= dy[PosW] ? AbsW'(-dy) : AbsW'(dy);
        az_q  <= dz[PosW] ? AbsW'(-dz) : AbsW'(dz);
        ang_q <= ang;
      end
      ST_SQ: begin
        sx_q    <= SqW'(ax_q) * SqW'(ax_q);
        sy_q    <= SqW'(ay_q) * SqW'(ay_q);
        sz_q    <= SqW'(az_q) * SqW'(az_q);
        hprod_q <= (WgtW+AngW)'(weight_q) * (WgtW+AngW)'(ang_q);
      end
      ST_SUM: begin
        s_q    <= SumW'(sx_q) + SumW'(sy_q) + SumW'(sz_q);
        term_q <= hround[WgtW+AngW -: WgtW+2];
        rem_q  <= '0;
        root_q <= '0;
        step_q <= 6'(RootW - 1);
      end
      ST_ROOT: begin
        s_q    <= {s_q[SumW-3:0], 2'b00};
        step_q <= step_q - 1'b1;
        if (rem_t >= trial) begin
          rem_q  <= rem_t - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_t;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // sequencer, search state and result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ego_x_q     <= '0;
      ego_y_q     <= '0;
      ego_z_q     <= '0;
      ego_hdg_q   <= '0;
      min_idx_q   <= '0;
      min_cost_q  <= CostMax;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_idx_q   <= '0;
      out_cost_q  <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (pop && out_valid_q) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            case (q_item_i.kind)
              KIND_EGO: begin
                ego_x_q    <= q_item_i.x;
                ego_y_q    <= q_item_i.y;
                ego_z_q    <= q_item_i.z;
                ego_hdg_q  <= q_item_i.hdg;
                min_idx_q  <= '0;
                min_cost_q <= CostMax;
                ovf_q      <= 1'b0;
                if (q_item_i.last) begin
                  out_valid_q <= 1'b1;
                  out_found_q <= 1'b0;
                  out_idx_q   <= '0;
                  out_cost_q  <= '0;
                  out_ovf_q   <= 1'b0;
                end
              end
              KIND_SKIP: begin
                ovf_q <= 1'b1;
                if (q_item_i.last) begin
                  out_valid_q <= 1'b1;
                  out_found_q <= 1'b1;
                  out_idx_q   <= min_idx_q;
                  out_cost_q  <= min_cost_q;
                  out_ovf_q   <= 1'b1;
                  min_idx_q   <= '0;
                  min_cost_q  <= CostMax;
                  ovf_q       <= 1'b0;
                end
              end
              KIND_EVAL: state_q <= ST_SQ;
              default: ;
            endcase
          end
        end
        ST_SQ:   state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_ROOT;
        ST_ROOT: if (step_q == '0) state_q <= ST_DONE;
        ST_DONE: begin
          state_q <= ST_IDLE;
          if (cur_last_q) begin
            out_valid_q <= 1'b1;
            out_found_q <= 1'b1;
            out_idx_q   <= better ? cur_idx_q : min_idx_q;
            out_cost_q  <= better ? cost : min_cost_q;
            out_ovf_q   <= ovf_q;
            min_idx_q   <= '0;
            min_cost_q  <= CostMax;
            ovf_q       <= 1'b0;
          end else if (better) begin
            min_idx_q  <= cur_idx_q;
            min_cost_q <= cost;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // root remainder never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> rem_q <= RemW'({root_q, 1'b0}))
    else $error("root remainder out of range");

  // an empty-path result carries zero index and cost
  a_empty_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_idx_q == '0 && out_cost_q == '0 && !out_ovf_q)
    else $error("empty-path result not cleared");

  // a closing beat is never taken over a waiting result
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_item_i.last |-> !out_valid_q)
    else $error("closing beat taken while result waits");

  // the point datapath only runs for evaluated points
  a_eval_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_item_i.kind != KIND_EVAL |=> state_q == ST_IDLE)
    else $error("sequencer left idle on a non-point beat");

endmodule

@@ rtl/weighted_closest_path_point_unit.sv @@
// Point beats step through the back end in order: idle, squares, sum, the
// one-bit-a-step square root, then done, where a closing point writes the result.
// Ego and over-capacity beats are handled in the idle state; a 4-entry queue lets
// the input run ahead. Results wait in a one-entry output slot until popped.
// Reset (rst_ni low, asynchronous) clears pose, weight, search state and queues.
module weighted_closest_path_point_unit import wcpp_pkg::*; #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [WgtW-1:0]        cfg_wdata_i,
  input  logic                   push,
  output logic                   full,
  input  logic                   req_type_i,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  input  logic signed [HdgW-1:0] heading_i,
  input  logic                   last_i,
  output logic                   empty,
  input  logic                   pop,
  output logic                   found_o,
  output logic [IdxW-1:0]        best_index_o,
  output logic [CostW-1:0]       best_cost_o,
  output logic                   overflow_o
);

  logic     q_push, q_full, q_pop, q_valid;
  fb_item_t q_in, q_out;

  // classify beats
  wcpp_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i, .rst_ni, .push, .full,
    .req_type_i, .pos_x_i, .pos_y_i, .pos_z_i, .heading_i, .last_i,
    .q_push_o(q_push), .q_item_o(q_in), .q_full_i(q_full)
  );

  // decoupling queue
  wcpp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .item_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .item_o(q_out), .valid_o(q_valid)
  );

  // cost evaluation and minimum search
  wcpp_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .q_valid_i(q_valid), .q_item_i(q_out), .q_pop_o(q_pop),
    .empty, .pop, .found_o, .best_index_o, .best_cost_o, .overflow_o
  );

endmodule
